>>> design/hold_relay_with_cooldown_failsafe_defines.svh
// assertion helpers used by the hold relay back end
`ifndef HOLD_RELAY_WITH_COOLDOWN_FAILSAFE_DEFINES_SVH
`define HOLD_RELAY_WITH_COOLDOWN_FAILSAFE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HRCF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hold relay check failed");

// next-cycle implication, disabled during reset
`define HRCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hold relay check failed");

`endif

>>> design/hrcf_pkg.sv
`timescale 1ns / 1ps
package hrcf_pkg;

   localparam int TIME_W      = 32;
   localparam int COOLDOWN_W  = 16;
   localparam int SOURCE_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // default depths of the two queues
   localparam int FRONT_DEPTH  = 2;
   localparam int RESULT_DEPTH = 2;

   // requester codes
   localparam logic [SOURCE_W-1:0] SRC_UNKNOWN = 2'd0;
   localparam logic [SOURCE_W-1:0] SRC_BUTTON  = 2'd1;
   localparam logic [SOURCE_W-1:0] SRC_STACK   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_PRESENT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_PRESENT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_ACTIVE_LOW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_INVERT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_MS       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_TIMEOUT_MS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTIFY_ENABLED    = 3'd7;

   // register reset values
   localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET      = 16'd1000;
   localparam logic [TIME_W-1:0]     STACK_TIMEOUT_RESET = 32'd60000;

   typedef enum logic {
      OP_POLL    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef struct packed {
      logic                  enabled;
      logic                  button_present;
      logic                  relay_present;
      logic                  button_active_low;
      logic                  relay_invert;
      logic [COOLDOWN_W-1:0] cooldown_ms;
      logic [TIME_W-1:0]     stack_timeout_ms;
      logic                  notify_enabled;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic [TIME_W-1:0]     now_ms;
      logic                  button_raw;
      logic                  button_read_ok;
      logic                  hold_on;
      logic                  notify_request;
      logic [SOURCE_W-1:0]   source;
   } item_type;

   typedef struct packed {
      logic                  relay_level;
      logic                  hold_state;
      logic                  accepted;
      logic                  notify_valid;
      logic                  notify_on;
      logic                  failsafe_fired;
      logic [SOURCE_W-1:0]   hold_source;
   } result_type;

endpackage

>>> design/hrcf_csr.sv
`timescale 1ns / 1ps
module hrcf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hrcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hrcf_pkg::CSR_DATA_W-1:0]    csr_data,
   output hrcf_pkg::cfg_type                  cfg
);
   import hrcf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_ENABLED:           cfg_in.enabled           = csr_data[0];
            CSR_BUTTON_PRESENT:    cfg_in.button_present    = csr_data[0];
            CSR_RELAY_PRESENT:     cfg_in.relay_present     = csr_data[0];
            CSR_BUTTON_ACTIVE_LOW: cfg_in.button_active_low = csr_data[0];
            CSR_RELAY_INVERT:      cfg_in.relay_invert      = csr_data[0];
            CSR_COOLDOWN_MS:       cfg_in.cooldown_ms       = csr_data[COOLDOWN_W-1:0];
            CSR_STACK_TIMEOUT_MS:  cfg_in.stack_timeout_ms  = csr_data[TIME_W-1:0];
            CSR_NOTIFY_ENABLED:    cfg_in.notify_enabled    = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled           <= 1'b0;
         cfg_ff.button_present    <= 1'b0;
         cfg_ff.relay_present     <= 1'b0;
         cfg_ff.button_active_low <= 1'b1;
         cfg_ff.relay_invert      <= 1'b0;
         cfg_ff.cooldown_ms       <= COOLDOWN_RESET;
         cfg_ff.stack_timeout_ms  <= STACK_TIMEOUT_RESET;
         cfg_ff.notify_enabled    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/hrcf_front.sv
`timescale 1ns / 1ps
module hrcf_front #(
   parameter int FRONT_DEPTH = hrcf_pkg::FRONT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_cmd,
   input  logic [hrcf_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                              req_button_raw,
   input  logic                              req_button_read_ok,
   input  logic                              req_hold_on,
   input  logic                              req_notify_request,
   input  logic [hrcf_pkg::SOURCE_W-1:0]     req_source,
   output logic                              item_valid,
   output hrcf_pkg::item_type                item,
   input  logic                              item_take
);
   import hrcf_pkg::*;

   localparam int PTR_W = $clog2(FRONT_DEPTH);
   localparam int CNT_W = $clog2(FRONT_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FRONT_DEPTH - 1);

   item_type          queue_ff [FRONT_DEPTH];
   item_type          item_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   // classify the beat as it comes in
   always_comb begin
      item_in.op             = req_cmd ? OP_REQUEST : OP_POLL;
      item_in.now_ms         = req_now_ms;
      item_in.button_raw     = req_button_raw;
      item_in.button_read_ok = req_button_read_ok;
      item_in.hold_on        = req_hold_on;
      item_in.notify_request = req_notify_request;
      item_in.source         = req_source;
   end

   assign full       = (count_ff == CNT_W'(FRONT_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

>>> design/hrcf_back.sv
`timescale 1ns / 1ps
`include "hold_relay_with_cooldown_failsafe_defines.svh"
module hrcf_back #(
   parameter int RESULT_DEPTH = hrcf_pkg::RESULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hrcf_pkg::cfg_type     cfg,
   input  logic                  item_valid,
   input  hrcf_pkg::item_type    item,
   output logic                  item_take,
   output logic                  empty,
   input  logic                  pop,
   output hrcf_pkg::result_type  result
);
   import hrcf_pkg::*;

   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RESULT_DEPTH - 1);

   // controller state
   logic                hold_ff, hold_in;
   logic                prev_pressed_ff, prev_pressed_in;
   logic [SOURCE_W-1:0] last_req_ff, last_req_in;
   logic [TIME_W-1:0]   cool_dl_ff, cool_dl_in;
   logic [TIME_W-1:0]   fail_dl_ff, fail_dl_in;
   logic                notice_ff, notice_in;
   logic                notice_lvl_ff, notice_lvl_in;

   // result queue
   result_type          res_mem_ff [RESULT_DEPTH];
   result_type          res_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                res_full, res_pop;

   logic [TIME_W-1:0]   cool_sum, stack_sum, cool_diff, fail_diff;
   logic                in_cool;

   assign res_full  = (count_ff == CNT_W'(RESULT_DEPTH));
   assign item_take = item_valid && !res_full;
   assign empty     = (count_ff == '0);
   assign res_pop   = pop && !empty;
   assign result    = res_mem_ff[rd_ptr_ff];

   // shared arithmetic: new deadlines from now_ms, differences against the stored deadlines
   assign cool_sum  = item.now_ms + TIME_W'(cfg.cooldown_ms);
   assign stack_sum = item.now_ms + cfg.stack_timeout_ms;
   assign cool_diff = item.now_ms - cool_dl_ff;
   assign fail_diff = item.now_ms - fail_dl_ff;
   assign in_cool   = (cool_dl_ff != '0) && cool_diff[TIME_W-1];

   always_comb begin
      logic pressed;
      logic was_on;
      logic fire;
      hold_in         = hold_ff;
      prev_pressed_in = prev_pressed_ff;
      last_req_in     = last_req_ff;
      cool_dl_in      = cool_dl_ff;
      fail_dl_in      = fail_dl_ff;
      notice_in       = notice_ff;
      notice_lvl_in   = notice_lvl_ff;
      res_in          = '0;
      pressed         = item.button_raw ^ cfg.button_active_low;
      was_on          = hold_ff;
      fire            = 1'b0;

      case (item.op)
         OP_POLL: begin
            if (!cfg.enabled) begin
               // forced off, silently
               hold_in    = 1'b0;
               fail_dl_in = '0;
            end else begin
               if (cfg.button_present && item.button_read_ok) begin
                  if (pressed) begin
                     if (!in_cool) begin
                        last_req_in = SRC_BUTTON;
                        fail_dl_in  = '0;
                        if (!hold_ff) begin
                           hold_in = 1'b1;
                           if (cfg.notify_enabled) begin
                              notice_in     = 1'b1;
                              notice_lvl_in = 1'b1;
                           end
                        end
                     end
                  end else if (prev_pressed_ff) begin
                     if (hold_ff) begin
                        hold_in = 1'b0;
                        if (cfg.notify_enabled) begin
                           notice_in     = 1'b1;
                           notice_lvl_in = 1'b0;
                        end
                     end
                     cool_dl_in = cool_sum;
                     fail_dl_in = '0;
                  end
                  prev_pressed_in = pressed;
               end
               // failsafe; a nonzero deadline here is still the stored one
               fire = hold_in && (last_req_in == SRC_STACK) && (fail_dl_in != '0)
                      && !fail_diff[TIME_W-1];
               if (fire) begin
                  hold_in    = 1'b0;
                  cool_dl_in = cool_sum;
                  fail_dl_in = '0;
                  if (cfg.notify_enabled) begin
                     notice_in     = 1'b1;
                     notice_lvl_in = 1'b0;
                  end
               end
               if (notice_in) begin
                  notice_in = 1'b0;
                  if (cfg.notify_enabled) begin
                     res_in.notify_valid = 1'b1;
                     res_in.notify_on    = notice_lvl_in;
                  end
               end
            end
         end
         OP_REQUEST: begin
            if (cfg.enabled && cfg.relay_present && !(item.hold_on && in_cool)) begin
               res_in.accepted = 1'b1;
               if (item.hold_on) begin
                  last_req_in = item.source;
                  fail_dl_in  = (item.source == SRC_STACK) ? stack_sum : '0;
               end
               if (hold_ff != item.hold_on) begin
                  hold_in = item.hold_on;
                  if (item.notify_request && cfg.notify_enabled) begin
                     notice_in     = 1'b1;
                     notice_lvl_in = item.hold_on;
                  end
               end
               if (!item.hold_on) begin
                  if (was_on) begin
                     cool_dl_in = cool_sum;
                  end
                  fail_dl_in = '0;
               end
            end
         end
         default: begin
            hold_in = hold_ff;
         end
      endcase

      res_in.relay_level    = cfg.relay_present && (hold_in ^ cfg.relay_invert);
      res_in.hold_state     = hold_in;
      res_in.failsafe_fired = fire;
      res_in.hold_source    = last_req_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (item_take) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (res_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (item_take && !res_pop) begin
         count_in = count_ff + 1'b1;
      end else if (res_pop && !item_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff         <= 1'b0;
         prev_pressed_ff <= 1'b0;
         last_req_ff     <= SRC_UNKNOWN;
         cool_dl_ff      <= '0;
         fail_dl_ff      <= '0;
         notice_ff       <= 1'b0;
         notice_lvl_ff   <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (item_take) begin
            hold_ff         <= hold_in;
            prev_pressed_ff <= prev_pressed_in;
            last_req_ff     <= last_req_in;
            cool_dl_ff      <= cool_dl_in;
            fail_dl_ff      <= fail_dl_in;
            notice_ff       <= notice_in;
            notice_lvl_ff   <= notice_lvl_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_mem_ff[wr_ptr_ff] <= res_in;
      end
   end

   `HRCF_ASSERT_NEXT(a_take_leaves_result, clock, reset, item_take, count_ff != '0)
   `HRCF_ASSERT_NOW(a_fire_drops_hold, clock, reset, item_take && res_in.failsafe_fired, !hold_in)
   `HRCF_ASSERT_NOW(a_accept_only_request, clock, reset, item_take && res_in.accepted, item.op == OP_REQUEST)
   `HRCF_ASSERT_NEXT(a_disabled_poll_off, clock, reset, item_take && item.op == OP_POLL && !cfg.enabled, !hold_ff && fail_dl_ff == '0)

endmodule

>>> design/hold_relay_with_cooldown_failsafe.sv
`timescale 1ns / 1ps
// Hold relay controller with release cooldown and stack failsafe. Each input beat
// is a poll carrying a button sample or a remote set-hold request, both stamped
// with the current millisecond time, and each beat produces exactly one result
// beat. While results are popped, the block sustains one beat per clock in each
// direction: the front queue takes a beat whenever full is low, the back end
// evaluates the oldest queued beat combinationally (the state update is one pass
// of adds and wrap-safe deadline compares) and writes the result into the result
// queue. A result reaches the rsp_ ports via the front and result queues, and
// stays there while empty is low until popped. Stalling on the result side fills
// the result queue and then the front queue before full rises. Registers are
// written through the csr_ channel, whose ready is always high; writes belong to
// idle periods, with no request beat pending and all results drained.
module hold_relay_with_cooldown_failsafe #(
   parameter int FRONT_DEPTH  = hrcf_pkg::FRONT_DEPTH,
   parameter int RESULT_DEPTH = hrcf_pkg::RESULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              push,
   output logic                              full,
   input  logic                              req_cmd,
   input  logic [hrcf_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                              req_button_raw,
   input  logic                              req_button_read_ok,
   input  logic                              req_hold_on,
   input  logic                              req_notify_request,
   input  logic [hrcf_pkg::SOURCE_W-1:0]     req_source,
   // result side
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_relay_level,
   output logic                              rsp_hold_state,
   output logic                              rsp_accepted,
   output logic                              rsp_notify_valid,
   output logic                              rsp_notify_on,
   output logic                              rsp_failsafe_fired,
   output logic [hrcf_pkg::SOURCE_W-1:0]     rsp_hold_source,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hrcf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hrcf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import hrcf_pkg::*;

   cfg_type    cfg;
   item_type   item;
   result_type result;
   logic       item_valid;
   logic       item_take;

   // register file
   hrcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // front: accept and classify request beats into a short queue
   hrcf_front #(
      .FRONT_DEPTH (FRONT_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_cmd            (req_cmd),
      .req_now_ms         (req_now_ms),
      .req_button_raw     (req_button_raw),
      .req_button_read_ok (req_button_read_ok),
      .req_hold_on        (req_hold_on),
      .req_notify_request (req_notify_request),
      .req_source         (req_source),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take)
   );

   // back: hold state, cooldown and failsafe deadlines, notice latch, result queue
   hrcf_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .empty      (empty),
      .pop        (pop),
      .result     (result)
   );

   // unpack the head result onto its ports
   assign rsp_relay_level    = result.relay_level;
   assign rsp_hold_state     = result.hold_state;
   assign rsp_accepted       = result.accepted;
   assign rsp_notify_valid   = result.notify_valid;
   assign rsp_notify_on      = result.notify_on;
   assign rsp_failsafe_fired = result.failsafe_fired;
   assign rsp_hold_source    = result.hold_source;

endmodule
